// ----- hw/rtl/hup_pkg.sv -----
// hup_pkg: shared types, header codes and name tables of the http upgrade header parser
// used by hup_parse_core and http_upgrade_header_parser_unit; no dependencies
package hup_pkg;

	localparam int unsigned HDR_COUNT    = 9;
	localparam int unsigned HDR_NAME_MAX = 23;
	localparam int unsigned NAME_W       = 8 * HDR_NAME_MAX;

	localparam logic [3:0] HDR_URI        = 4'd0;
	localparam logic [3:0] HDR_HOST       = 4'd1;
	localparam logic [3:0] HDR_CONNECTION = 4'd2;
	localparam logic [3:0] HDR_KEY1       = 4'd3;
	localparam logic [3:0] HDR_KEY2       = 4'd4;
	localparam logic [3:0] HDR_PROTOCOL   = 4'd5;
	localparam logic [3:0] HDR_UPGRADE    = 4'd6;
	localparam logic [3:0] HDR_ORIGIN     = 4'd7;
	localparam logic [3:0] HDR_CHALLENGE  = 4'd8;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;

	localparam logic [11:0] VALUE_LIMIT_RESET = 12'd4031;

	typedef struct packed {
		logic [3:0]  header_id;
		logic [7:0]  value_byte;
		logic        byte_stored;
		logic        value_closed;
		logic        value_overflow;
		logic        header_matched;
		logic [11:0] value_length;
		logic        parse_complete;
		logic        plain_http;
	} hup_res_t;

	function automatic logic [4:0] hdr_size(input logic [3:0] n);
		logic [4:0] s;
		unique case (n)
			HDR_URI:        s = 5'd4;
			HDR_HOST:       s = 5'd5;
			HDR_CONNECTION: s = 5'd11;
			HDR_KEY1:       s = 5'd19;
			HDR_KEY2:       s = 5'd19;
			HDR_PROTOCOL:   s = 5'd23;
			HDR_UPGRADE:    s = 5'd8;
			HDR_ORIGIN:     s = 5'd7;
			HDR_CHALLENGE:  s = 5'd2;
			default:        s = 5'd0;
		endcase
		return s;
	endfunction

	// character p of name n; only meaningful for p below hdr_size(n)
	function automatic logic [7:0] hdr_char(input logic [3:0] n, input logic [4:0] p);
		logic [NAME_W-1:0] text;
		logic [4:0]        idx;
		unique case (n)
			HDR_URI:        text = NAME_W'("GET ");
			HDR_HOST:       text = NAME_W'("Host:");
			HDR_CONNECTION: text = NAME_W'("Connection:");
			HDR_KEY1:       text = NAME_W'("Sec-WebSocket-Key1:");
			HDR_KEY2:       text = NAME_W'("Sec-WebSocket-Key2:");
			HDR_PROTOCOL:   text = NAME_W'("Sec-WebSocket-Protocol:");
			HDR_UPGRADE:    text = NAME_W'("Upgrade:");
			HDR_ORIGIN:     text = NAME_W'("Origin:");
			HDR_CHALLENGE:  text = NAME_W'({CHAR_CR, CHAR_LF});
			default:        text = '0;
		endcase
		idx = hdr_size(n) - 5'd1 - p;
		return text[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- hw/rtl/http_upgrade_header_parser_unit.sv -----
// http_upgrade_header_parser_unit: top level, stream ports, limit register and result skid
// depends on hup_pkg and hup_parse_core
// an accepted word's result is registered in out_q, or in skid_q if the master side stalls
// one word per cycle unless skid_q is full; name match and value update are combinational
// a two-entry result buffer keeps the slave side open while one result waits
// reset: asynchronous, active low; parser collects a name, all lengths zero, limit 4031
module http_upgrade_header_parser_unit import hup_pkg::*; #(
	parameter int unsigned NAME_BUFFER_SIZE = 64,
	parameter int unsigned CHALLENGE_BYTES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        value_limit_we,
	input  logic [11:0] value_limit_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// value_byte, byte_stored, value_closed, value_overflow, header_matched,
	// value_length, parse_complete, plain_http, zero fill
	output logic [31:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser    // header_id
);

	logic [11:0] value_limit_q;
	hup_res_t    res, out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        push, pop;

	assign s_axis_tready = !skid_valid_q;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = out_valid_q && m_axis_tready;

	hup_parse_core #(
		.NAME_BUFFER_SIZE (NAME_BUFFER_SIZE),
		.CHALLENGE_BYTES  (CHALLENGE_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (push),
		.data_byte   (s_axis_tdata),
		.restart     (s_axis_tuser),
		.value_limit (value_limit_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_limit_q <= VALUE_LIMIT_RESET;
		end else if (value_limit_we) begin
			value_limit_q <= value_limit_wdata;
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (push && !pop) begin
			skid_valid_q <= 1'b1;
		end else if (!push && pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push && (!out_valid_q || pop)) begin
			out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.header_id;
	assign m_axis_tdata  = {6'd0, out_q.plain_http, out_q.parse_complete, out_q.value_length,
		out_q.header_matched, out_q.value_overflow, out_q.value_closed, out_q.byte_stored,
		out_q.value_byte};

endmodule

// ----- hw/rtl/hup_parse_core.sv -----
// hup_parse_core: parser state, parallel name match and per-header value lengths
// depends on hup_pkg; result is combinational for the word being accepted
module hup_parse_core import hup_pkg::*; #(
	parameter int unsigned NAME_BUFFER_SIZE,
	parameter int unsigned CHALLENGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic [11:0] value_limit,
	output hup_res_t    res
);

	localparam int unsigned POS_W = $clog2(NAME_BUFFER_SIZE);

	typedef enum logic [3:0] {
		PH_URI        = 4'd0,
		PH_HOST       = 4'd1,
		PH_CONNECTION = 4'd2,
		PH_KEY1       = 4'd3,
		PH_KEY2       = 4'd4,
		PH_PROTOCOL   = 4'd5,
		PH_UPGRADE    = 4'd6,
		PH_ORIGIN     = 4'd7,
		PH_CHALLENGE  = 4'd8,
		PH_NAME       = 4'd9,
		PH_SKIP       = 4'd10,
		PH_SKIP_CR    = 4'd11,
		PH_DONE       = 4'd12
	} phase_t;

	phase_t                 phase_q, phase_e, phase_d;
	logic [POS_W-1:0]       pos_q, pos_e, pos_d;
	logic [HDR_COUNT-1:0]   mask_q, mask_e, mask_d, mask_new;
	logic [11:0]            lens_q [HDR_COUNT];
	logic                   len_we;
	logic [3:0]             len_wa;
	logic [11:0]            len_wd;
	logic [11:0]            cur, cur_inc;
	logic                   hit_found;
	logic [3:0]             hit_id;

	assign phase_e = restart ? PH_NAME : phase_q;
	assign pos_e   = restart ? '0 : pos_q;
	assign mask_e  = restart ? '1 : mask_q;
	assign cur     = (phase_e < PH_NAME) ? lens_q[4'(phase_e)] : '0;
	assign cur_inc = cur + 12'd1;

	// all nine names compared at once, lowest completed name wins
	always_comb begin
		mask_new  = '0;
		hit_found = 1'b0;
		hit_id    = HDR_URI;
		for (int n = 0; n < HDR_COUNT; n++) begin
			if (mask_e[n] && int'(pos_e) < int'(hdr_size(4'(n)))
					&& hdr_char(4'(n), pos_e[4:0]) == data_byte) begin
				mask_new[n] = 1'b1;
				if (int'(pos_e) + 1 == int'(hdr_size(4'(n))) && !hit_found) begin
					hit_found = 1'b1;
					hit_id    = 4'(n);
				end
			end
		end
	end

	always_comb begin
		res     = '0;
		phase_d = phase_e;
		pos_d   = pos_e;
		mask_d  = mask_e;
		len_we  = 1'b0;
		len_wa  = HDR_URI;
		len_wd  = '0;
		unique case (phase_e) inside
			[PH_URI:PH_CHALLENGE]: begin
				res.header_id = 4'(phase_e);
				if (cur == '0 && data_byte == CHAR_SPACE) begin
					// leading space dropped
				end else if (phase_e == PH_URI && data_byte == CHAR_SPACE) begin
					res.value_closed = 1'b1;
					phase_d          = PH_SKIP;
				end else if (cur >= value_limit) begin
					res.value_overflow = 1'b1;
					phase_d            = PH_SKIP;
				end else if (phase_e != PH_CHALLENGE && data_byte == CHAR_CR) begin
					res.value_closed = 1'b1;
					phase_d          = PH_SKIP_CR;
				end else begin
					len_we          = 1'b1;
					len_wa          = 4'(phase_e);
					len_wd          = cur_inc;
					res.byte_stored = 1'b1;
					res.value_byte  = data_byte;
					if (phase_e == PH_CHALLENGE && cur_inc >= 12'(CHALLENGE_BYTES)) begin
						res.value_closed = 1'b1;
						phase_d          = PH_DONE;
					end
				end
				res.value_length = len_we ? cur_inc : cur;
			end
			PH_NAME: begin
				if (pos_e == POS_W'(NAME_BUFFER_SIZE - 1)) begin
					phase_d = PH_SKIP;
				end else begin
					pos_d  = pos_e + POS_W'(1);
					mask_d = mask_new;
					if (hit_found) begin
						phase_d            = phase_t'(hit_id);
						len_we             = 1'b1;
						len_wa             = hit_id;
						len_wd             = '0;
						res.header_matched = 1'b1;
						res.header_id      = hit_id;
						if (hit_id == HDR_CHALLENGE && lens_q[HDR_UPGRADE] == '0) begin
							phase_d = PH_DONE;
						end
					end else if (data_byte == CHAR_COLON) begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (data_byte == CHAR_CR) begin
					phase_d = PH_SKIP_CR;
				end
			end
			PH_SKIP_CR: begin
				phase_d = (data_byte == CHAR_LF) ? PH_NAME : PH_SKIP;
				pos_d   = '0;
				mask_d  = '1;
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_NAME;
			end
		endcase
		res.parse_complete = (phase_d == PH_DONE);
		res.plain_http     = (phase_d == PH_DONE) && (lens_q[HDR_UPGRADE] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			pos_q   <= '0;
			mask_q  <= '1;
			for (int n = 0; n < HDR_COUNT; n++) begin
				lens_q[n] <= '0;
			end
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			mask_q  <= mask_d;
			if (len_we) begin
				lens_q[len_wa] <= len_wd;
			end
		end
	end

	a_stored_excl: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.byte_stored |->
			!res.value_overflow && !res.header_matched && res.value_length != '0)
		else $error("stored word also flagged or length zero");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_DONE && !restart |=> phase_q == PH_DONE)
		else $error("left completed phase without restart");

	a_plain_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.plain_http |-> res.parse_complete)
		else $error("plain http outside completed phase");

	a_close_skip: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.value_closed && !res.byte_stored |=>
			phase_q == PH_SKIP || phase_q == PH_SKIP_CR)
		else $error("closed value did not move to skipping");

endmodule
